// File: rtl/cfb_pkg.sv
// Shared types, constants and functions of the command frame builder.
package cfb_pkg;

    localparam int unsigned NUM_PARAMS   = 6;
    localparam int unsigned IDX_W        = 4;   // byte index in a frame, up to 13
    localparam int unsigned LEN_W        = 3;   // data length, 1..7

    localparam logic [7:0] SYNC_BYTE     = 8'h55;
    localparam logic [7:0] PKT_TYPE_CMN  = 8'h05;
    localparam logic [7:0] CRC_POLY      = 8'h07;

    // Fixed byte positions in a frame.
    localparam logic [IDX_W-1:0] IDX_SYNC    = 4'd0;
    localparam logic [IDX_W-1:0] IDX_LEN_HI  = 4'd1;
    localparam logic [IDX_W-1:0] IDX_LEN_LO  = 4'd2;
    localparam logic [IDX_W-1:0] IDX_OPT_LEN = 4'd3;
    localparam logic [IDX_W-1:0] IDX_TYPE    = 4'd4;
    localparam logic [IDX_W-1:0] IDX_HDR_CRC = 4'd5;
    localparam logic [IDX_W-1:0] IDX_CMD     = 4'd6;

    typedef struct packed {
        logic load;      // latch a new input word
        logic advance;   // current frame byte taken, move on
    } t_dp_cmd;

    typedef struct packed {
        logic last;      // current byte ends the frame
    } t_dp_status;

    // Data length per command code; 0 means no entry.
    function automatic logic [LEN_W-1:0] cmd_len(input logic [7:0] code);
        logic [LEN_W-1:0] len;
        case (code) inside
            8'd1:          len = 3'd5;
            [8'd2:8'd7]:   len = 3'd1;
            8'd9:          len = 3'd3;
            8'd10:         len = 3'd1;
            8'd11:         len = 3'd7;
            8'd12:         len = 3'd6;
            8'd13:         len = 3'd1;
            8'd14:         len = 3'd3;
            8'd15:         len = 3'd1;
            8'd28:         len = 3'd2;
            default:       len = 3'd0;
        endcase
        return len;
    endfunction

    // One byte through CRC-8, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/cfb_dp.sv
// Datapath: input word holding, frame byte selection and running CRC-8.
module cfb_dp
    import cfb_pkg::*;
(
    input  logic                   i_clk,
    input  logic [8*(NUM_PARAMS+1)-1:0] i_word,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic [7:0]             o_byte,
    output logic                   o_unsup
);

    logic [7:0]       r_cmd;
    logic [7:0]       r_par [NUM_PARAMS];
    logic [LEN_W-1:0] r_len;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_crc;

    logic [IDX_W-1:0] w_end_idx;
    logic [7:0]       w_byte;
    logic             w_unsup;

    assign w_unsup   = (r_len == '0);
    assign w_end_idx = IDX_CMD + IDX_W'(r_len);

    always_comb begin
        if (w_unsup) begin
            w_byte = 8'h00;
        end else if (r_idx == w_end_idx) begin
            w_byte = r_crc;
        end else begin
            case (r_idx)
                IDX_SYNC:    w_byte = SYNC_BYTE;
                IDX_LEN_HI:  w_byte = 8'h00;
                IDX_LEN_LO:  w_byte = {5'd0, r_len};
                IDX_OPT_LEN: w_byte = 8'h00;
                IDX_TYPE:    w_byte = PKT_TYPE_CMN;
                IDX_HDR_CRC: w_byte = r_crc;
                IDX_CMD:     w_byte = r_cmd;
                4'd7:        w_byte = r_par[0];
                4'd8:        w_byte = r_par[1];
                4'd9:        w_byte = r_par[2];
                4'd10:       w_byte = r_par[3];
                4'd11:       w_byte = r_par[4];
                4'd12:       w_byte = r_par[5];
                default:     w_byte = 8'h00;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_word[7:0];
            for (int p = 0; p < NUM_PARAMS; p++) begin
                r_par[p] <= i_word[8*(p+1) +: 8];
            end
            r_len <= cmd_len(i_word[7:0]);
            r_idx <= '0;
            r_crc <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + 1'b1;
            // CRC restarts after sync and after the header CRC
            if (r_idx == IDX_SYNC || r_idx == IDX_HDR_CRC) begin
                r_crc <= '0;
            end else begin
                r_crc <= crc8_byte(r_crc, w_byte);
            end
        end
    end

    assign o_byte        = w_byte;
    assign o_unsup       = w_unsup;
    assign o_status.last = w_unsup || (r_idx == w_end_idx);

endmodule

// File: rtl/cfb_ctrl.sv
// Controller: accepts one input word, then steps the datapath through the frame.
module cfb_ctrl
    import cfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_SEND
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    assign o_cmd.load    = r_in_ready && i_in_valid;
    assign o_cmd.advance = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_in_ready <= 1'b1;
                    if (r_in_ready && i_in_valid) begin
                        r_state     <= S_SEND;
                        r_in_ready  <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                end
                S_SEND: begin
                    if (r_out_valid && i_out_ready && i_status.last) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b0;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/command_frame_builder_crc8.sv
// Top level of the command frame builder with CRC-8 checks.
//
// Takes one command word (a common-command code plus six parameter bytes)
// and streams out the serial command frame one byte per word: sync 0x55,
// data length high/low, optional length 0, packet type 5, header CRC-8,
// the command byte, length-1 parameter bytes and a data CRC-8 over command
// and parameters (poly 0x07, init 0, MSB first). Unused parameter bytes are
// ignored. A code without a length entry yields a single word with data 0,
// tlast 1 and tuser 1. A frame of data length L takes 7+L output words
// (8 to 14). The rate is set by the byte-wide output: one frame byte and
// one CRC-8 byte update per cycle while the sink is ready. Input and
// output never overlap; a new word is taken only after the last byte of
// the current frame has been accepted.
module command_frame_builder_crc8
    import cfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // cmd, param_0 .. param_5
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // frame_byte
    output logic        m_axis_tlast,   // last
    output logic        m_axis_tuser    // unsupported
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    cfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // payload and CRC; output fields are combinational from its registers
    cfb_dp u_dp (
        .i_clk    (i_clk),
        .i_word   (s_axis_tdata),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_byte   (m_axis_tdata),
        .o_unsup  (m_axis_tuser)
    );

    assign m_axis_tlast = w_status.last;

endmodule
